// File: hw/rtl/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Shared constants and types of the sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TIME_W      = 32;
    localparam int TAG_W       = 8;
    localparam int STATUS_W    = 2;

    localparam logic [STATUS_W-1:0] ST_ADDED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FIRED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_POP = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] trigger;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic pop;
    } stq_ctrl_t;

endpackage

// File: hw/rtl/stq_cell.sv
// ----------------------------------------------------------------------------
// stq_cell
// One slot of the sorted chain: holds an entry, keeps it, takes the new entry,
// or takes the word of its left or right neighbor.
// ----------------------------------------------------------------------------
module stq_cell
    import stq_pkg::*;
(
    input  logic      clk,
    input  stq_ctrl_t ctrl,
    input  logic      occupied,
    input  entry_t    new_entry,
    input  entry_t    left_entry,
    input  logic      left_keep,
    input  entry_t    right_entry,
    output entry_t    entry,
    output logic      keep
);

    entry_t entry_reg;
    entry_t entry_next;

    // Hold when this slot sorts strictly before the new trigger.
    assign keep  = occupied && (entry_reg.trigger < new_entry.trigger);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (!keep)
            begin
                entry_next = left_keep ? new_entry : left_entry;
            end
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// File: hw/rtl/sorted_timer_queue.sv
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Pending timers kept in ascending trigger order in a shift-insert cell chain.
// ----------------------------------------------------------------------------
// Channel  | Handshake        | Fields
// ---------+------------------+----------------------------------------------
// command  | start / busy     | action, now_time, delay, tag
// result   | done (strobe)    | status, fired_tag, load_timer, load_value,
//          |                  | occupancy
//
// A word is taken when start is high and busy is low. The trigger sum is
// registered when the word is taken; the chain compares and shifts while
// busy is high; the result is shown for one cycle after that. Reset empties
// the queue at once. The receiver cannot stall; a new word may be taken
// while the previous result is shown.
// ----------------------------------------------------------------------------
module sorted_timer_queue
    import stq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                action,
    input  logic [TIME_W-1:0]   now_time,
    input  logic [TIME_W-1:0]   delay,
    input  logic [TAG_W-1:0]    tag,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [TAG_W-1:0]    fired_tag,
    output logic                load_timer,
    output logic [TIME_W-1:0]   load_value,
    output logic [CNT_W-1:0]    occupancy
);

    logic                busy_reg;
    logic                act_reg;
    logic [TIME_W-1:0]   trig_reg;
    logic [TIME_W-1:0]   delay_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    logic                done_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [TAG_W-1:0]    fired_tag_reg;
    logic [TAG_W-1:0]    fired_tag_next;
    logic                load_timer_reg;
    logic                load_timer_next;
    logic [TIME_W-1:0]   load_value_reg;
    logic [TIME_W-1:0]   load_value_next;

    stq_ctrl_t           ctrl;
    entry_t              new_entry;
    entry_t              cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_keep;

    logic                accept;
    logic                full;
    logic                empty;

    assign accept    = start && !busy_reg;
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign new_entry = '{trigger: trig_reg, tag: tag_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= accept;
            done_reg  <= busy_reg;
            count_reg <= count_next;
        end
    end

    // Register the word and its absolute trigger, and the result fields while busy.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= action;
            trig_reg  <= now_time + delay;
            delay_reg <= delay;
            tag_reg   <= tag;
        end
        if (busy_reg)
        begin
            status_reg     <= status_next;
            fired_tag_reg  <= fired_tag_next;
            load_timer_reg <= load_timer_next;
            load_value_reg <= load_value_next;
            occupancy      <= count_next;
        end
    end

    always_comb
    begin
        ctrl            = '{ins: 1'b0, pop: 1'b0};
        count_next      = count_reg;
        status_next     = ST_ADDED;
        fired_tag_next  = '0;
        load_timer_next = 1'b0;
        load_value_next = '0;
        if (busy_reg)
        begin
            if (act_reg == ACT_ADD)
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctrl.ins   = 1'b1;
                    count_next = count_reg + 1'b1;
                    // New entry becomes the head: arm the timer with its delay.
                    if (!cell_keep[0])
                    begin
                        load_timer_next = 1'b1;
                        load_value_next = delay_reg;
                    end
                end
            end
            else if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                ctrl.pop       = 1'b1;
                count_next     = count_reg - 1'b1;
                status_next    = ST_FIRED;
                fired_tag_next = cell_entry[0].tag;
                if (count_reg != CNT_W'(1))
                begin
                    load_timer_next = 1'b1;
                    load_value_next = cell_entry[1].trigger - cell_entry[0].trigger;
                end
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_k;

            if (gi == 0)
            begin : g_first
                assign left_e = '0;
                assign left_k = 1'b1;
            end
            else
            begin : g_mid
                assign left_e = cell_entry[gi-1];
                assign left_k = cell_keep[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_inner
                assign right_e = cell_entry[gi+1];
            end

            stq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (CNT_W'(gi) < count_reg),
                .new_entry   (new_entry),
                .left_entry  (left_e),
                .left_keep   (left_k),
                .right_entry (right_e),
                .entry       (cell_entry[gi]),
                .keep        (cell_keep[gi])
            );
        end
    endgenerate

    assign busy       = busy_reg;
    assign done       = done_reg;
    assign status     = status_reg;
    assign fired_tag  = fired_tag_reg;
    assign load_timer = load_timer_reg;
    assign load_value = load_value_reg;

`ifndef SYNTHESIS
    a_busy_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("result strobe missing after busy cycle");

    a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !$past(busy)))
        else $error("accepted word did not raise busy");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (occupancy <= CNT_W'(QUEUE_DEPTH)))
        else $error("occupancy beyond queue depth");

    a_full_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (!load_timer && occupancy == CNT_W'(QUEUE_DEPTH)))
        else $error("dropped add loaded timer or queue not full");

    a_empty_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (!load_timer && occupancy == '0))
        else $error("pop on empty queue changed state");
`endif

endmodule

// File: sim/tb_sorted_timer_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_timer_queue
// Self-checking bench: directed adds and pops, then random fill and drain
// phases with random gaps between words. Every result is checked field by
// field against a sorted-list prediction of the queue.
// ----------------------------------------------------------------------------
module tb_sorted_timer_queue;
    import stq_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 1440;
    localparam int PHASE_LEN    = 40;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    fired_tag;
        logic                load_timer;
        logic [TIME_W-1:0]   load_value;
        logic [CNT_W-1:0]    occupancy;
    } outcome_t;

    class timer_scoreboard;
        logic [TIME_W-1:0] held_trigger [QUEUE_DEPTH];
        logic [TAG_W-1:0]  held_tag [QUEUE_DEPTH];
        int                held_count;
        outcome_t          pending_outcomes [$];
        int                errors;

        function new();
            held_count = 0;
            errors     = 0;
        endfunction

        // Update the sorted list for one accepted word and queue its outcome.
        function void note_word(logic act, logic [TIME_W-1:0] now,
                                logic [TIME_W-1:0] dly, logic [TAG_W-1:0] tg);
            outcome_t          o;
            logic [TIME_W-1:0] trig;
            logic [TIME_W-1:0] old_trig;
            int                pos;
            o = '0;
            if (act == ACT_ADD) begin
                if (held_count >= QUEUE_DEPTH) begin
                    o.status = ST_FULL;
                end
                else begin
                    trig = now + dly;
                    pos  = 0;
                    // equal triggers: newest goes first
                    while (pos < held_count && held_trigger[pos] < trig)
                        pos++;
                    for (int i = held_count; i > pos; i--)
                    begin
                        held_trigger[i] = held_trigger[i-1];
                        held_tag[i]     = held_tag[i-1];
                    end
                    held_trigger[pos] = trig;
                    held_tag[pos]     = tg;
                    held_count++;
                    o.status = ST_ADDED;
                    if (pos == 0)
                    begin
                        o.load_timer = 1'b1;
                        o.load_value = dly;
                    end
                end
            end
            else if (held_count == 0) begin
                o.status = ST_EMPTY;
            end
            else begin
                old_trig    = held_trigger[0];
                o.status    = ST_FIRED;
                o.fired_tag = held_tag[0];
                for (int i = 1; i < held_count; i++)
                begin
                    held_trigger[i-1] = held_trigger[i];
                    held_tag[i-1]     = held_tag[i];
                end
                held_count--;
                if (held_count > 0)
                begin
                    o.load_timer = 1'b1;
                    o.load_value = held_trigger[0] - old_trig;
                end
            end
            o.occupancy = held_count[CNT_W-1:0];
            pending_outcomes.push_back(o);
        endfunction

        function void check_result(outcome_t got);
            outcome_t exp_o;
            if (pending_outcomes.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result with nothing pending: st=%0d tag=%0h ld=%0b val=%0h occ=%0d",
                             $time, got.status, got.fired_tag, got.load_timer,
                             got.load_value, got.occupancy);
                return;
            end
            exp_o = pending_outcomes.pop_front();
            if (got.status !== exp_o.status || got.fired_tag !== exp_o.fired_tag ||
                got.load_timer !== exp_o.load_timer ||
                got.load_value !== exp_o.load_value ||
                got.occupancy !== exp_o.occupancy) begin
                errors++;
                if (errors <= 10)
                begin
                    $display("%0t: mismatch exp st=%0d tag=%0h ld=%0b val=%0h occ=%0d",
                             $time, exp_o.status, exp_o.fired_tag, exp_o.load_timer,
                             exp_o.load_value, exp_o.occupancy);
                    $display("%0t:          got st=%0d tag=%0h ld=%0b val=%0h occ=%0d",
                             $time, got.status, got.fired_tag, got.load_timer,
                             got.load_value, got.occupancy);
                end
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                action;
    logic [TIME_W-1:0]   now_time;
    logic [TIME_W-1:0]   delay;
    logic [TAG_W-1:0]    tag;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    fired_tag;
    logic                load_timer;
    logic [TIME_W-1:0]   load_value;
    logic [CNT_W-1:0]    occupancy;

    timer_scoreboard sb;
    int              cycles;

    sorted_timer_queue u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .now_time   (now_time),
        .delay      (delay),
        .tag        (tag),
        .done       (done),
        .status     (status),
        .fired_tag  (fired_tag),
        .load_timer (load_timer),
        .load_value (load_value),
        .occupancy  (occupancy)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_sorted_timer_queue: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result('{status, fired_tag, load_timer, load_value, occupancy});
    end

    // Hold start across back-to-back words; drop it only for a gap.
    task automatic send_word(logic act, logic [TIME_W-1:0] now,
                             logic [TIME_W-1:0] dly, logic [TAG_W-1:0] tg);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        action   <= act;
        now_time <= now;
        delay    <= dly;
        tag      <= tg;
        do
            @(posedge clk);
        while (busy);
        sb.note_word(act, now, dly, tg);
    endtask

    task automatic send_random(int add_pct);
        logic              act;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] dly;
        act = ($urandom_range(0, 99) < add_pct) ? ACT_ADD : ACT_POP;
        case ($urandom_range(0, 3))
            0:
            begin
                now = $urandom;
                dly = $urandom;
            end
            1:
            begin
                now = $urandom;
                dly = $urandom_range(0, 255);
            end
            // narrow window: many equal triggers
            2:
            begin
                now = $urandom_range(0, 7) * 16;
                dly = $urandom_range(0, 31);
            end
            default:
            begin
                now = $urandom;
                dly = $urandom_range(0, 1) ? '1 : '0;
            end
        endcase
        send_word(act, now, dly, TAG_W'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int add_pct;
        sb       = new();
        clk      = 1'b0;
        rst_n    = 1'b0;
        start    = 1'b0;
        action   = ACT_ADD;
        now_time = '0;
        delay    = '0;
        tag      = '0;
        cycles   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pop, extremes, wrap, ties, insert behind head
        send_word(ACT_POP, 32'h0, 32'h0, 8'h00);
        send_word(ACT_ADD, 32'h0, 32'h0, 8'h00);
        send_word(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_word(ACT_ADD, 32'd100, 32'd50, 8'h01);
        send_word(ACT_ADD, 32'd100, 32'd50, 8'h02);
        send_word(ACT_ADD, 32'hFFFF_FFF0, 32'h20, 8'h03);
        repeat (5) send_word(ACT_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_word(ACT_POP, 32'h0, 32'h0, 8'h00);
        send_word(ACT_ADD, 32'd1000, 32'd5, 8'hAA);
        send_word(ACT_ADD, 32'd0, 32'd500, 8'h55);
        send_word(ACT_ADD, 32'd0, 32'd500, 8'h0F);
        repeat (3) send_word(ACT_POP, 32'h0, 32'h0, 8'h00);

        // random fill and drain phases; full-add phases overflow the queue
        for (int p = 0; p < RANDOM_WORDS / PHASE_LEN; p++)
        begin
            case ($urandom_range(0, 3))
                0:       add_pct = 15;
                1:       add_pct = 50;
                2:       add_pct = 80;
                default: add_pct = 100;
            endcase
            repeat (PHASE_LEN) send_random(add_pct);
        end
        start <= 1'b0;

        while (sb.pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_sorted_timer_queue: PASS");
        else
            $display("tb_sorted_timer_queue: FAIL");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/stq_pkg.sv
hw/rtl/stq_cell.sv
hw/rtl/sorted_timer_queue.sv
sim/tb_sorted_timer_queue.sv
